// File: hdl/ihfpl_pkg.sv
// shared types, codes and the hex digit decode for the hex flash page loader
`timescale 1ns / 1ps

package ihfpl_pkg;

  // input item: one text character or an end-of-transfer marker
  typedef struct packed {
    logic       operation;
    logic [7:0] char_in;
  } in_item_t;

  // result item: word fill or page write
  typedef struct packed {
    logic        command;
    logic [31:0] flash_address;
    logic [15:0] word_data;
    logic        last;
  } out_item_t;

  // operation codes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  // command codes
  localparam logic CMD_FILL = 1'b0;
  localparam logic CMD_PAGE = 1'b1;

  // characters
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] HEX_TEN      = 8'd10;

  // record types of the hex format
  localparam logic [7:0] REC_TYPE_DATA = 8'h00;
  localparam logic [7:0] REC_TYPE_EOF  = 8'h01;
  localparam logic [7:0] REC_TYPE_SEG  = 8'h02;
  localparam logic [7:0] REC_TYPE_LIN  = 8'h04;

  // work kinds passed from front to back
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FLUSH = 2'd1;
  localparam logic [1:0] KIND_SEG   = 2'd2;
  localparam logic [1:0] KIND_LIN   = 2'd3;

  // shortest line that is decoded, line feed included
  localparam int MIN_LINE_CHARS = 11;
  // header bytes: length, offset high, offset low, type
  localparam int HDR_BYTES = 4;
  // base shifts for segment and linear records
  localparam int SEG_SHIFT = 4;
  localparam int LIN_SHIFT = 16;

  // clipped record length and pair count widths
  localparam int LEN_W  = 5;
  localparam int PAIR_W = 5;

  // header of one decoded record in the work queue
  typedef struct packed {
    logic [1:0]       kind;
    logic [LEN_W-1:0] len;
    logic [15:0]      offset;
  } rec_hdr_t;

  // uppercase-only hex digit, wraps for anything else
  function automatic logic [7:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c > CHAR_NINE) begin
      v = c - CHAR_UPPER_A + HEX_TEN;
    end else begin
      v = c - CHAR_ZERO;
    end
    return v;
  endfunction

endpackage

// File: hdl/ihfpl_fifo.sv
// two-entry queue with push/full and pop/empty sides
`timescale 1ns / 1ps

module ihfpl_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  logic [1:0]       cnt_r, cnt_nxt;
  logic [WIDTH-1:0] head_r, tail_r;
  logic             do_push, do_pop;

  // transfer qualifiers
  assign full    = (cnt_r == CNT_TWO);
  assign empty   = (cnt_r == CNT_NONE);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = head_r;
  assign cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_NONE;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // entries: head is always the oldest
  always_ff @(posedge clk) begin
    if (do_pop) begin
      if (cnt_r == CNT_TWO) begin
        head_r <= tail_r;
      end else if (do_push) begin
        head_r <= din;
      end
    end else if (do_push) begin
      if (cnt_r == CNT_NONE) begin
        head_r <= din;
      end else begin
        tail_r <= din;
      end
    end
  end

endmodule

// File: hdl/ihfpl_front.sv
// front end: collects a line, decodes hex pairs on the fly, classifies records
`timescale 1ns / 1ps

module ihfpl_front #(
  parameter int  LINE_CHARS       = 46,
  parameter int  MAX_RECORD_BYTES = 16,
  localparam int DATA_BYTES       = ((MAX_RECORD_BYTES + 1) / 2) * 2,
  localparam int REC_W            = $bits(ihfpl_pkg::rec_hdr_t) + 8 * DATA_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ihfpl_pkg::in_item_t  in_item,
  output logic                 full,
  output logic                 rec_push,
  output logic [REC_W-1:0]     rec_data,
  input  logic                 rec_full
);

  import ihfpl_pkg::*;

  localparam int CNT_W = $clog2(LINE_CHARS + 1);

  logic [CNT_W-1:0]        pos_r, pos_nxt;
  logic [3:0]              nib_r;
  logic [7:0]              hdr_r [HDR_BYTES];
  logic [7:0]              dat_r [DATA_BYTES];
  logic                    accept, is_char, is_lf, store;
  logic                    nib_we, pair_we, data_we;
  logic [7:0]              hv, pair_byte;
  logic [PAIR_W-1:0]       pidx, didx, npairs;
  logic [CNT_W-1:0]        cnt;
  logic                    line_ok, kind_ok;
  logic [1:0]              kind;
  rec_hdr_t                hdr;
  logic [8*DATA_BYTES-1:0] dat_vec;

  // input transfer
  assign full    = rec_full;
  assign accept  = push && !rec_full;
  assign is_char = (in_item.operation == OP_CHAR);
  assign is_lf   = (in_item.char_in == CHAR_LF);
  assign store   = (pos_r < CNT_W'(LINE_CHARS));

  // odd positions give the high digit, even positions complete a pair
  assign hv        = hex_val(in_item.char_in);
  assign pair_byte = {nib_r, 4'b0000} + hv;
  assign pidx      = PAIR_W'(pos_r >> 1) - PAIR_W'(1);
  assign didx      = pidx - PAIR_W'(HDR_BYTES);
  assign nib_we    = accept && is_char && store && pos_r[0];
  assign pair_we   = accept && is_char && store && !pos_r[0] && (pos_r != '0);
  assign data_we   = pair_we && (pidx >= PAIR_W'(HDR_BYTES));

  // line length with the terminating character, if it still fits
  assign cnt     = store ? (pos_r + CNT_W'(1)) : pos_r;
  assign line_ok = (cnt >= CNT_W'(MIN_LINE_CHARS));
  assign npairs  = PAIR_W'((cnt - CNT_W'(3)) >> 1);

  // record type classification
  always_comb begin
    kind    = KIND_DATA;
    kind_ok = 1'b1;
    case (hdr_r[3])
      REC_TYPE_DATA: kind = KIND_DATA;
      REC_TYPE_EOF:  kind = KIND_FLUSH;
      REC_TYPE_SEG:  kind = KIND_SEG;
      REC_TYPE_LIN:  kind = KIND_LIN;
      default:       kind_ok = 1'b0;
    endcase
  end

  // data bytes past the decoded pairs read as zero
  always_comb begin
    for (int j = 0; j < DATA_BYTES; j++) begin
      dat_vec[8*j +: 8] = (PAIR_W'(j + HDR_BYTES) < npairs) ? dat_r[j] : 8'h00;
    end
  end

  // record to the back end
  always_comb begin
    hdr.kind   = (in_item.operation == OP_END) ? KIND_FLUSH : kind;
    hdr.len    = (hdr_r[0] > 8'(MAX_RECORD_BYTES)) ? LEN_W'(MAX_RECORD_BYTES)
                                                    : LEN_W'(hdr_r[0]);
    hdr.offset = {hdr_r[1], hdr_r[2]};
  end
  assign rec_data = {hdr, dat_vec};
  assign rec_push = accept &&
                    ((in_item.operation == OP_END) || (is_lf && line_ok && kind_ok));

  // character position
  always_comb begin
    pos_nxt = pos_r;
    if (accept && is_char) begin
      if (is_lf) begin
        pos_nxt = '0;
      end else if (store) begin
        pos_nxt = pos_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // decoded line bytes
  always_ff @(posedge clk) begin
    if (nib_we) begin
      nib_r <= hv[3:0];
    end
    for (int j = 0; j < HDR_BYTES; j++) begin
      if (pair_we && (pidx == PAIR_W'(j))) begin
        hdr_r[j] <= pair_byte;
      end
    end
    for (int j = 0; j < DATA_BYTES; j++) begin
      if (data_we && (didx == PAIR_W'(j))) begin
        dat_r[j] <= pair_byte;
      end
    end
  end

endmodule

// File: hdl/ihfpl_back.sv
// back end: word fills and page writes from records, one a cycle if not stalled
`timescale 1ns / 1ps

module ihfpl_back #(
  parameter int  PAGE_BYTES       = 128,
  parameter int  MAX_RECORD_BYTES = 16,
  localparam int DATA_BYTES       = ((MAX_RECORD_BYTES + 1) / 2) * 2,
  localparam int REC_W            = $bits(ihfpl_pkg::rec_hdr_t) + 8 * DATA_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rec_empty,
  input  logic [REC_W-1:0]     rec_data,
  output logic                 rec_pop,
  input  logic                 oq_full,
  output logic                 oq_push,
  output ihfpl_pkg::out_item_t oq_item
);

  import ihfpl_pkg::*;

  localparam int WORDS  = DATA_BYTES / 2;
  localparam int WL_W   = $clog2(WORDS + 1);
  localparam int FILL_W = $clog2(PAGE_BYTES + 2);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WORD = 2'd1;
  localparam logic [1:0] ST_PAGE = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [31:0]             base_r, base_nxt;
  logic [31:0]             wa_r, wa_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt, fill_add;
  logic [WL_W-1:0]         wl_r, wl_nxt, wl_load;
  logic                    pg_last_r, pg_last_nxt;
  logic [8*DATA_BYTES-1:0] dat_r, dat_nxt;
  rec_hdr_t                hdr;
  logic [8*DATA_BYTES-1:0] rdat;
  logic [31:0]             rec_base;
  logic                    page_hit, last_word;

  assign {hdr, rdat} = rec_data;
  assign fill_add    = fill_r + FILL_W'(2);
  assign page_hit    = (fill_add >= FILL_W'(PAGE_BYTES));
  assign last_word   = (wl_r == WL_W'(1));
  assign wl_load     = WL_W'(({1'b0, hdr.len} + (LEN_W + 1)'(1)) >> 1);
  assign rec_base    = {16'h0000, rdat[7:0], rdat[15:8]};

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    base_nxt    = base_r;
    wa_nxt      = wa_r;
    fill_nxt    = fill_r;
    wl_nxt      = wl_r;
    pg_last_nxt = pg_last_r;
    dat_nxt     = dat_r;
    rec_pop     = 1'b0;
    oq_push     = 1'b0;
    oq_item     = '0;
    case (state_r)
      ST_IDLE: begin
        if (!rec_empty) begin
          rec_pop = 1'b1;
          case (hdr.kind)
            KIND_DATA: begin
              wa_nxt  = base_r + {16'h0000, hdr.offset};
              dat_nxt = rdat;
              wl_nxt  = wl_load;
              if (wl_load != '0) begin
                state_nxt = ST_WORD;
              end
            end
            default: begin
              // flush, segment base and linear base all close the page
              if (hdr.kind == KIND_SEG) begin
                base_nxt = rec_base << SEG_SHIFT;
              end else if (hdr.kind == KIND_LIN) begin
                base_nxt = rec_base << LIN_SHIFT;
              end
              wl_nxt      = '0;
              pg_last_nxt = 1'b1;
              if (fill_r != '0) begin
                state_nxt = ST_PAGE;
              end
            end
          endcase
        end
      end
      ST_WORD: begin
        if (!oq_full) begin
          oq_push               = 1'b1;
          oq_item.command       = CMD_FILL;
          oq_item.flash_address = wa_r;
          oq_item.word_data     = dat_r[15:0];
          oq_item.last          = last_word && !page_hit;
          wa_nxt                = wa_r + 32'd2;
          fill_nxt              = fill_add;
          dat_nxt               = dat_r >> 16;
          wl_nxt                = wl_r - WL_W'(1);
          if (page_hit) begin
            state_nxt   = ST_PAGE;
            pg_last_nxt = last_word;
          end else if (last_word) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_PAGE: begin
        if (!oq_full) begin
          oq_push               = 1'b1;
          oq_item.command       = CMD_PAGE;
          oq_item.flash_address = wa_r - 32'd2;
          oq_item.word_data     = 16'h0000;
          oq_item.last          = pg_last_r;
          fill_nxt              = '0;
          state_nxt             = (wl_r != '0) ? ST_WORD : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and address state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      base_r    <= '0;
      wa_r      <= '0;
      fill_r    <= '0;
      wl_r      <= '0;
      pg_last_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      base_r    <= base_nxt;
      wa_r      <= wa_nxt;
      fill_r    <= fill_nxt;
      wl_r      <= wl_nxt;
      pg_last_r <= pg_last_nxt;
    end
  end

  // data bytes of the record in progress, shifted one word per fill
  always_ff @(posedge clk) begin
    dat_r <= dat_nxt;
  end

endmodule

// File: hdl/intel_hex_flash_page_loader.sv
// top level of the hex flash page loader: front end, record queue, back end, result queue
`timescale 1ns / 1ps

// Takes a hex text stream one character per transfer and issues flash word
// fills and page writes. The front end takes one character every cycle,
// decoding hex pairs as they arrive, and on a line feed that ends a valid
// line hands a decoded record (or, for an end-of-transfer item, a flush) to a
// two-entry record queue; it holds off input only while that queue is full.
// The back end loads a record, then issues its results in turn, stalling
// while the output queue is full: a data record of length n gives ceil(n/2)
// fills plus a page write whenever the page fills, at most nine results for
// one line. Results wait in a two-entry output queue, so a line of 11 or
// more characters normally covers the back end's work for the previous line.
module intel_hex_flash_page_loader #(
  parameter int PAGE_BYTES       = 128,
  parameter int LINE_CHARS       = 46,
  parameter int MAX_RECORD_BYTES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ihfpl_pkg::in_item_t  in_item,
  output logic                 full,
  output logic                 empty,
  input  logic                 pop,
  output ihfpl_pkg::out_item_t out_item
);

  import ihfpl_pkg::*;

  localparam int DATA_BYTES = ((MAX_RECORD_BYTES + 1) / 2) * 2;
  localparam int REC_W      = $bits(rec_hdr_t) + 8 * DATA_BYTES;
  localparam int OUT_W      = $bits(out_item_t);

  logic             rec_push, rec_full, rec_pop, rec_empty;
  logic [REC_W-1:0] rec_in, rec_out;
  logic             oq_push, oq_full;
  out_item_t        oq_item;
  logic [OUT_W-1:0] oq_out;

  // line collection and classification
  ihfpl_front #(
    .LINE_CHARS       (LINE_CHARS),
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .rec_push (rec_push),
    .rec_data (rec_in),
    .rec_full (rec_full)
  );

  // decoded records between the two halves
  ihfpl_fifo #(
    .WIDTH (REC_W)
  ) u_rec_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .din   (rec_in),
    .full  (rec_full),
    .pop   (rec_pop),
    .dout  (rec_out),
    .empty (rec_empty)
  );

  // fill and page write sequencing
  ihfpl_back #(
    .PAGE_BYTES       (PAGE_BYTES),
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_empty (rec_empty),
    .rec_data  (rec_out),
    .rec_pop   (rec_pop),
    .oq_full   (oq_full),
    .oq_push   (oq_push),
    .oq_item   (oq_item)
  );

  // result queue
  ihfpl_fifo #(
    .WIDTH (OUT_W)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .din   (oq_item),
    .full  (oq_full),
    .pop   (pop),
    .dout  (oq_out),
    .empty (empty)
  );

  assign out_item = out_item_t'(oq_out);

endmodule
